// ===== hw/rtl/nearest_segment_hit_test_assert.svh =====
// ----------------------------------------------------------------------------
// Nearest segment hit test assertion macros
// Shared property forms for the hit test block, clocked on clk with rst_n.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SEGMENT_HIT_TEST_ASSERT_SVH
`define NEAREST_SEGMENT_HIT_TEST_ASSERT_SVH

// Same-cycle implication.
`define NSHT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsht same-cycle check failed");

// Next-cycle implication.
`define NSHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsht next-cycle check failed");

`endif

// ===== hw/rtl/nsht_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest segment hit test package
// Shared constants and types for the front queue and the back engine.
// ----------------------------------------------------------------------------
package nsht_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int NET_ID_BITS_DEF = 16;
    localparam int GRID_BITS       = 16;
    localparam int DIST_BITS       = 20;
    localparam int RADIUS_SCALE    = 10;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic first;
        logic last;
        logic zero_len;
    } item_ctl_t;

endpackage

// ===== hw/rtl/nsht_front.sv =====
// ----------------------------------------------------------------------------
// Nearest segment hit test front end
// Accepts segment beats, flags zero-length segments and queues them.
// ----------------------------------------------------------------------------
module nsht_front #(
    parameter int COORD_BITS  = nsht_pkg::COORD_BITS_DEF,
    parameter int NET_ID_BITS = nsht_pkg::NET_ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_BITS-1:0]  query_x,
    input  logic signed [COORD_BITS-1:0]  query_y,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic        [NET_ID_BITS-1:0] segment_net,
    input  logic                          first_of_query,
    input  logic                          last_of_query,
    output logic                          q_valid,
    input  logic                          q_pop,
    output logic signed [COORD_BITS-1:0]  q_px,
    output logic signed [COORD_BITS-1:0]  q_py,
    output logic signed [COORD_BITS-1:0]  q_ax,
    output logic signed [COORD_BITS-1:0]  q_ay,
    output logic signed [COORD_BITS-1:0]  q_bx,
    output logic signed [COORD_BITS-1:0]  q_by,
    output logic        [NET_ID_BITS-1:0] q_net,
    output nsht_pkg::item_ctl_t           q_ctl
);
    import nsht_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int IW  = 6 * C + NET_ID_BITS + 3;
    localparam int PTW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    logic [IW-1:0]  mem [QUEUE_DEPTH];
    logic [PTW-1:0] wr_ptr_reg;
    logic [PTW-1:0] rd_ptr_reg;
    logic [CNW-1:0] count_reg;
    logic           do_push;
    logic           do_pop;
    item_ctl_t      in_ctl;
    logic [IW-1:0]  in_word;
    logic [IW-1:0]  rd_word;

    assign full    = (count_reg == CNW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    assign in_ctl.first    = first_of_query;
    assign in_ctl.last     = last_of_query;
    assign in_ctl.zero_len = (start_x == end_x) && (start_y == end_y);
    assign in_word = {in_ctl, segment_net, end_y, end_x, start_y, start_x, query_y, query_x};

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= in_word;
        end
    end

    assign rd_word = mem[rd_ptr_reg];
    assign {q_ctl, q_net, q_by, q_bx, q_ay, q_ax, q_py, q_px} = rd_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/nsht_back.sv =====
// ----------------------------------------------------------------------------
// Nearest segment hit test back end
// Projects the point onto each segment, takes the integer distance with a
// shared divider and a digit-serial root, and tracks the nearest hit.
// ----------------------------------------------------------------------------
module nsht_back #(
    parameter int COORD_BITS  = nsht_pkg::COORD_BITS_DEF,
    parameter int NET_ID_BITS = nsht_pkg::NET_ID_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  logic signed [COORD_BITS-1:0]       q_px,
    input  logic signed [COORD_BITS-1:0]       q_py,
    input  logic signed [COORD_BITS-1:0]       q_ax,
    input  logic signed [COORD_BITS-1:0]       q_ay,
    input  logic signed [COORD_BITS-1:0]       q_bx,
    input  logic signed [COORD_BITS-1:0]       q_by,
    input  logic        [NET_ID_BITS-1:0]      q_net,
    input  nsht_pkg::item_ctl_t                q_ctl,
    input  logic        [nsht_pkg::DIST_BITS-1:0] radius,
    output logic                               empty,
    input  logic                               pop,
    output logic                               hit_found,
    output logic signed [COORD_BITS-1:0]       hit_x,
    output logic signed [COORD_BITS-1:0]       hit_y,
    output logic        [NET_ID_BITS-1:0]      hit_net,
    output logic        [nsht_pkg::DIST_BITS-1:0] hit_distance
);
    import nsht_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * C + 2;
    localparam int NW   = 2 * C + 3;
    localparam int MW   = 3 * C + 1;
    localparam int VW   = C + 2;
    localparam int SW   = 2 * C + 4;
    localparam int RB   = C + 2;
    localparam int RW   = C + 4;
    localparam int CW   = $clog2(C + 2);
    localparam int CMPW = (RB > DIST_BITS) ? RB : DIST_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_NUM_X, S_NUM_Y, S_DEN_X, S_DEN_Y, S_CLASSIFY,
        S_P_HI, S_P_LO, S_P_ADD, S_DIV, S_FIX,
        S_SQ_X, S_SQ_Y, S_SQ_SUM, S_SQRT, S_UPDATE, S_FINISH
    } state_t;

    state_t                    state_reg;
    logic signed [C-1:0]       px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic        [NET_ID_BITS-1:0] net_reg;
    logic                      last_reg;
    logic signed [DW-1:0]      dx_reg, dy_reg, wx_reg, wy_reg;
    logic signed [PW-1:0]      prod_a_reg, prod_b_reg;
    logic signed [NW-1:0]      num_reg, den_reg;
    logic                      sel_reg;
    logic        [2*C-1:0]     phi_reg;
    logic        [2*C:0]       plo_reg;
    logic        [2*C:0]       rem_reg;
    logic        [C-1:0]       low_reg;
    logic        [C-1:0]       quo_reg;
    logic        [CW-1:0]      cnt_reg;
    logic signed [C-1:0]       cx_reg, cy_reg;
    logic        [PW-1:0]      sq_a_reg, sq_b_reg;
    logic        [SW-1:0]      rad_reg;
    logic        [RB-1:0]      root_reg;
    logic        [RW-1:0]      srem_reg;
    logic        [DIST_BITS-1:0] best_dist_reg;
    logic signed [C-1:0]       best_x_reg, best_y_reg;
    logic        [NET_ID_BITS-1:0] best_net_reg;
    logic                      found_reg;
    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic signed [C-1:0]       out_x_reg, out_y_reg;
    logic        [NET_ID_BITS-1:0] out_net_reg;
    logic        [DIST_BITS-1:0] out_dist_reg;

    logic signed [C-1:0]       sel_a;
    logic signed [DW-1:0]      sel_d;
    logic        [C-1:0]       sel_m;
    logic        [MW-1:0]      prod_full;
    logic        [2*C+1:0]     div_t;
    logic        [2*C+1:0]     den_u;
    logic signed [VW-1:0]      fix_v;
    logic signed [VW-1:0]      fix_res;
    logic signed [DW-1:0]      ex_s, ey_s;
    logic        [DW-1:0]      ex_m, ey_m;
    logic        [RW+1:0]      sq_t;
    logic        [RW+1:0]      sq_trial;
    logic                      out_free;

    always_comb
    begin
        sel_a     = sel_reg ? ay_reg : ax_reg;
        sel_d     = sel_reg ? dy_reg : dx_reg;
        sel_m     = sel_d[DW-1] ? C'(-sel_d) : C'(sel_d);
        prod_full = (MW'(phi_reg) << (C + 1)) + MW'(plo_reg);
        den_u     = den_reg[2*C+1:0];
        div_t     = {rem_reg, low_reg[C-1]};
        fix_v     = sel_d[DW-1] ? (VW'(sel_a) - $signed({2'b00, quo_reg}))
                                : (VW'(sel_a) + $signed({2'b00, quo_reg}));
        fix_res   = fix_v;
        if (rem_reg != '0)
        begin
            if (!sel_d[DW-1] && fix_v < 0)
            begin
                fix_res = fix_v + VW'(1);
            end
            else if (sel_d[DW-1] && fix_v > 0)
            begin
                fix_res = fix_v - VW'(1);
            end
        end
        ex_s     = DW'(cx_reg) - DW'(px_reg);
        ey_s     = DW'(cy_reg) - DW'(py_reg);
        ex_m     = ex_s[DW-1] ? DW'(-ex_s) : DW'(ex_s);
        ey_m     = ey_s[DW-1] ? DW'(-ey_s) : DW'(ey_s);
        sq_t     = {srem_reg, rad_reg[SW-1:SW-2]};
        sq_trial = (RW+2)'({root_reg, 2'b01});
    end

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign out_free     = !out_valid_reg || pop;
    assign empty        = !out_valid_reg;
    assign hit_found    = out_found_reg;
    assign hit_x        = out_x_reg;
    assign hit_y        = out_y_reg;
    assign hit_net      = out_net_reg;
    assign hit_distance = out_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            px_reg        <= '0;
            py_reg        <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            net_reg       <= '0;
            last_reg      <= 1'b0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            prod_a_reg    <= '0;
            prod_b_reg    <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            sel_reg       <= 1'b0;
            phi_reg       <= '0;
            plo_reg       <= '0;
            rem_reg       <= '0;
            low_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            sq_a_reg      <= '0;
            sq_b_reg      <= '0;
            rad_reg       <= '0;
            root_reg      <= '0;
            srem_reg      <= '0;
            best_dist_reg <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_net_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_net_reg   <= '0;
            out_dist_reg  <= '0;
        end
        else
        begin
            if (pop && out_valid_reg && !(state_reg == S_FINISH && last_reg))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        px_reg   <= q_px;
                        py_reg   <= q_py;
                        ax_reg   <= q_ax;
                        ay_reg   <= q_ay;
                        bx_reg   <= q_bx;
                        by_reg   <= q_by;
                        net_reg  <= q_net;
                        last_reg <= q_ctl.last;
                        dx_reg   <= DW'(q_bx) - DW'(q_ax);
                        dy_reg   <= DW'(q_by) - DW'(q_ay);
                        wx_reg   <= DW'(q_px) - DW'(q_ax);
                        wy_reg   <= DW'(q_py) - DW'(q_ay);
                        if (q_ctl.first)
                        begin
                            best_dist_reg <= radius;
                            best_x_reg    <= '0;
                            best_y_reg    <= '0;
                            best_net_reg  <= '0;
                            found_reg     <= 1'b0;
                        end
                        state_reg <= q_ctl.zero_len ? S_FINISH : S_NUM_X;
                    end
                end
                S_NUM_X:
                begin
                    prod_a_reg <= PW'(wx_reg) * PW'(dx_reg);
                    state_reg  <= S_NUM_Y;
                end
                S_NUM_Y:
                begin
                    prod_b_reg <= PW'(wy_reg) * PW'(dy_reg);
                    state_reg  <= S_DEN_X;
                end
                S_DEN_X:
                begin
                    num_reg    <= NW'(prod_a_reg) + NW'(prod_b_reg);
                    prod_a_reg <= PW'(dx_reg) * PW'(dx_reg);
                    state_reg  <= S_DEN_Y;
                end
                S_DEN_Y:
                begin
                    prod_b_reg <= PW'(dy_reg) * PW'(dy_reg);
                    state_reg  <= S_CLASSIFY;
                end
                S_CLASSIFY:
                begin
                    den_reg <= NW'(prod_a_reg) + NW'(prod_b_reg);
                    if (num_reg <= 0)
                    begin
                        cx_reg    <= ax_reg;
                        cy_reg    <= ay_reg;
                        state_reg <= S_SQ_X;
                    end
                    else if (num_reg >= NW'(prod_a_reg) + NW'(prod_b_reg))
                    begin
                        cx_reg    <= bx_reg;
                        cy_reg    <= by_reg;
                        state_reg <= S_SQ_X;
                    end
                    else
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= S_P_HI;
                    end
                end
                S_P_HI:
                begin
                    phi_reg   <= (2*C)'(num_reg[2*C:C+1]) * (2*C)'(sel_m);
                    state_reg <= S_P_LO;
                end
                S_P_LO:
                begin
                    plo_reg   <= (2*C+1)'(num_reg[C:0]) * (2*C+1)'(sel_m);
                    state_reg <= S_P_ADD;
                end
                S_P_ADD:
                begin
                    rem_reg   <= prod_full[MW-1:C];
                    low_reg   <= prod_full[C-1:0];
                    quo_reg   <= '0;
                    cnt_reg   <= CW'(C - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_t >= den_u)
                    begin
                        rem_reg <= (2*C+1)'(div_t - den_u);
                        quo_reg <= {quo_reg[C-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_t[2*C:0];
                        quo_reg <= {quo_reg[C-2:0], 1'b0};
                    end
                    low_reg <= {low_reg[C-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    if (sel_reg)
                    begin
                        cy_reg    <= C'(fix_res);
                        state_reg <= S_SQ_X;
                    end
                    else
                    begin
                        cx_reg    <= C'(fix_res);
                        sel_reg   <= 1'b1;
                        state_reg <= S_P_HI;
                    end
                end
                S_SQ_X:
                begin
                    sq_a_reg  <= PW'(ex_m) * PW'(ex_m);
                    state_reg <= S_SQ_Y;
                end
                S_SQ_Y:
                begin
                    sq_b_reg  <= PW'(ey_m) * PW'(ey_m);
                    state_reg <= S_SQ_SUM;
                end
                S_SQ_SUM:
                begin
                    rad_reg   <= SW'(sq_a_reg) + SW'(sq_b_reg);
                    root_reg  <= '0;
                    srem_reg  <= '0;
                    cnt_reg   <= CW'(RB - 1);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_t >= sq_trial)
                    begin
                        srem_reg <= RW'(sq_t - sq_trial);
                        root_reg <= {root_reg[RB-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= sq_t[RW-1:0];
                        root_reg <= {root_reg[RB-2:0], 1'b0};
                    end
                    rad_reg <= {rad_reg[SW-3:0], 2'b00};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (CMPW'(root_reg) < CMPW'(best_dist_reg))
                    begin
                        best_dist_reg <= DIST_BITS'(root_reg);
                        best_x_reg    <= cx_reg;
                        best_y_reg    <= cy_reg;
                        best_net_reg  <= net_reg;
                        found_reg     <= 1'b1;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_x_reg     <= best_x_reg;
                        out_y_reg     <= best_y_reg;
                        out_net_reg   <= best_net_reg;
                        out_dist_reg  <= best_dist_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/nearest_segment_hit_test.sv =====
// ----------------------------------------------------------------------------
// Nearest segment hit test
// Finds the wire segment nearest to a query point within ten grid pitches.
// ----------------------------------------------------------------------------
// Segments enter through a queue-like port: a beat is taken when push is high
// and full is low. A two-entry queue sits in front of the compute engine, so
// segments can be pushed while the engine works.
// A segment whose nearest point lies strictly inside it runs the
// one-bit-per-cycle divider once per coordinate and then the one-bit-per-cycle
// square root.
// A segment whose nearest point is an endpoint runs only the square root.
// Zero-length segments skip the distance steps and never become the hit.
// The result of a query appears on the hit ports when empty falls, at the
// clock edge that ends its last segment, and is taken when pop is high.
// One result register holds it; while it is not taken, the engine waits at
// the end of the next query and the queue fills and raises full.
// The grid pitch register is written through cfg_we and cfg_wdata.
// Reset clears the queue, the result and the nearest-hit state and sets the
// grid pitch to one.
// ----------------------------------------------------------------------------
`include "nearest_segment_hit_test_assert.svh"

module nearest_segment_hit_test #(
    parameter int COORD_BITS  = nsht_pkg::COORD_BITS_DEF,
    parameter int NET_ID_BITS = nsht_pkg::NET_ID_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nsht_pkg::GRID_BITS-1:0]    cfg_wdata,
    input  logic                              push,
    output logic                              full,
    input  logic signed [COORD_BITS-1:0]      query_x,
    input  logic signed [COORD_BITS-1:0]      query_y,
    input  logic signed [COORD_BITS-1:0]      start_x,
    input  logic signed [COORD_BITS-1:0]      start_y,
    input  logic signed [COORD_BITS-1:0]      end_x,
    input  logic signed [COORD_BITS-1:0]      end_y,
    input  logic        [NET_ID_BITS-1:0]     segment_net,
    input  logic                              first_of_query,
    input  logic                              last_of_query,
    output logic                              empty,
    input  logic                              pop,
    output logic                              hit_found,
    output logic signed [COORD_BITS-1:0]      hit_x,
    output logic signed [COORD_BITS-1:0]      hit_y,
    output logic        [NET_ID_BITS-1:0]     hit_net,
    output logic        [nsht_pkg::DIST_BITS-1:0] hit_distance
);
    import nsht_pkg::*;

    logic [GRID_BITS-1:0]          grid_spacing_reg;
    logic [DIST_BITS-1:0]          radius;
    logic                          q_valid;
    logic                          q_pop;
    logic signed [COORD_BITS-1:0]  q_px, q_py, q_ax, q_ay, q_bx, q_by;
    logic        [NET_ID_BITS-1:0] q_net;
    item_ctl_t                     q_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_spacing_reg <= GRID_BITS'(1);
        end
        else if (cfg_we)
        begin
            grid_spacing_reg <= cfg_wdata;
        end
    end

    assign radius = DIST_BITS'(DIST_BITS'(grid_spacing_reg) * DIST_BITS'(RADIUS_SCALE));

    nsht_front #(
        .COORD_BITS  (COORD_BITS),
        .NET_ID_BITS (NET_ID_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .query_x        (query_x),
        .query_y        (query_y),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .segment_net    (segment_net),
        .first_of_query (first_of_query),
        .last_of_query  (last_of_query),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_px           (q_px),
        .q_py           (q_py),
        .q_ax           (q_ax),
        .q_ay           (q_ay),
        .q_bx           (q_bx),
        .q_by           (q_by),
        .q_net          (q_net),
        .q_ctl          (q_ctl)
    );

    nsht_back #(
        .COORD_BITS  (COORD_BITS),
        .NET_ID_BITS (NET_ID_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_px         (q_px),
        .q_py         (q_py),
        .q_ax         (q_ax),
        .q_ay         (q_ay),
        .q_bx         (q_bx),
        .q_by         (q_by),
        .q_net        (q_net),
        .q_ctl        (q_ctl),
        .radius       (radius),
        .empty        (empty),
        .pop          (pop),
        .hit_found    (hit_found),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .hit_net      (hit_net),
        .hit_distance (hit_distance)
    );

    `NSHT_ASSERT_IMPL(a_pop_has_item, q_pop, q_valid)
    `NSHT_ASSERT_IMPL(a_miss_is_zero, !empty && !hit_found, hit_x == '0 && hit_y == '0 && hit_net == '0)
    `NSHT_ASSERT_NEXT(a_pop_frees_slot, q_pop && !(push && !full), !full)

endmodule
